### rtl/core/lebuf_pkg.sv
package lebuf_pkg;

    localparam int MAX_LEN_DEF     = 256;
    localparam int NUM_EXCLUDE_DEF = 4;
    localparam int NUM_EXCL_REGS   = 4;
    localparam int CFG_IDX_W       = 4;

    localparam logic [3:0] OP_INSERT    = 4'd0;
    localparam logic [3:0] OP_BACKSPACE = 4'd1;
    localparam logic [3:0] OP_DELETE    = 4'd2;
    localparam logic [3:0] OP_FORWARD   = 4'd3;
    localparam logic [3:0] OP_BACK      = 4'd4;
    localparam logic [3:0] OP_HOME      = 4'd5;
    localparam logic [3:0] OP_END       = 4'd6;
    localparam logic [3:0] OP_SET       = 4'd7;
    localparam logic [3:0] OP_READ      = 4'd8;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_NOEFFECT = 2'd1;
    localparam logic [1:0] ST_EXCLUDED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] char_code;
        logic [7:0] position;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] text_length;
        logic [8:0] cursor_index;
        logic       cursor_at_end;
        logic [7:0] read_char;
    } t_out;

    typedef struct packed {
        logic capture;
        logic exec;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cnt_nz;
        logic cnt_last;
        logic ins_mid;
    } t_sts;

endpackage

### rtl/core/lebuf_ctrl.sv
module lebuf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  lebuf_pkg::t_sts i_sts,
    output lebuf_pkg::t_cmd o_cmd
);
    import lebuf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ROUTE,
        S_SH_RD,
        S_SH_WR,
        S_INS,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_ROUTE;
            end
            S_ROUTE: begin
                if (i_sts.cnt_nz) begin
                    n_state = S_SH_RD;
                end else if (i_sts.ins_mid) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                o_cmd.shift_rd = 1'b1;
                n_state        = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                if (!i_sts.cnt_last) begin
                    n_state = S_SH_RD;
                end else if (i_sts.ins_mid) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // The result waits here until the output register is free.
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> i_sts.cnt_nz)
        else $error("shift write with an empty move count");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result presented outside the done state");
`endif

endmodule

### rtl/core/lebuf_dp.sv
module lebuf_dp #(
    parameter int MAX_LEN     = lebuf_pkg::MAX_LEN_DEF,
    parameter int NUM_EXCLUDE = lebuf_pkg::NUM_EXCLUDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lebuf_pkg::t_in                 i_in_data,
    input  logic                           i_cfg_valid,
    input  logic [lebuf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  lebuf_pkg::t_cmd                i_cmd,
    output lebuf_pkg::t_sts                o_sts,
    output lebuf_pkg::t_out                o_out_data
);
    import lebuf_pkg::*;

    localparam int AW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW       = $clog2(MAX_LEN + 1);
    localparam int CW       = (LW > 8) ? LW : 8;
    localparam int NUM_USED = (NUM_EXCLUDE < NUM_EXCL_REGS) ? NUM_EXCLUDE : NUM_EXCL_REGS;

    logic [7:0]    mem [MAX_LEN];
    logic [7:0]    r_mem_q;

    logic [3:0]    r_op;
    logic [7:0]    r_ch;
    logic [7:0]    r_pos;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_cur, n_cur;
    logic          r_end, n_end;
    logic [7:0]    r_excl [NUM_USED];
    logic [AW-1:0] r_src, n_src;
    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_up, n_up;
    logic          r_ins_mid, n_ins_mid;
    logic [AW-1:0] r_ins_addr, n_ins_addr;
    logic [1:0]    r_status, n_status;
    logic          r_rd_ok, n_rd_ok;
    t_out          r_out;

    logic          excluded;
    logic          len_nz;
    logic          full;
    logic          pos_ok;
    logic          app_we;
    logic          set_op;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata;

    always_comb begin
        excluded = 1'b0;
        for (int k = 0; k < NUM_USED; k++) begin
            if (r_excl[k] == r_ch) begin
                excluded = 1'b1;
            end
        end
    end

    assign len_nz = (r_len != '0);
    assign full   = (r_len == LW'(MAX_LEN));
    assign pos_ok = (CW'(r_pos) < CW'(r_len));

    // Decision for one event; the stored state is always normalized between events.
    always_comb begin
        n_len      = r_len;
        n_cur      = r_cur;
        n_end      = r_end;
        n_status   = ST_NOEFFECT;
        n_cnt      = '0;
        n_src      = r_src;
        n_up       = r_up;
        n_ins_mid  = 1'b0;
        n_ins_addr = r_ins_addr;
        n_rd_ok    = 1'b0;
        app_we     = 1'b0;
        set_op     = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (excluded) begin
                    n_status = ST_EXCLUDED;
                end else if (full) begin
                    n_status = ST_FULL;
                end else if (r_end) begin
                    app_we   = 1'b1;
                    n_len    = r_len + LW'(1);
                    n_status = ST_APPLIED;
                end else begin
                    n_cnt      = r_len - r_cur;
                    n_src      = AW'(r_len - LW'(1));
                    n_up       = 1'b1;
                    n_ins_mid  = 1'b1;
                    n_ins_addr = AW'(r_cur);
                    n_len      = r_len + LW'(1);
                    n_cur      = r_cur + LW'(1);
                    n_status   = ST_APPLIED;
                end
            end
            OP_BACKSPACE: begin
                if (len_nz) begin
                    if (r_end) begin
                        n_len    = r_len - LW'(1);
                        n_status = ST_APPLIED;
                    end else if (r_cur != '0) begin
                        n_cnt    = r_len - r_cur;
                        n_src    = AW'(r_cur);
                        n_up     = 1'b0;
                        n_len    = r_len - LW'(1);
                        n_cur    = r_cur - LW'(1);
                        n_status = ST_APPLIED;
                    end
                end
            end
            OP_DELETE: begin
                if (len_nz && !r_end) begin
                    n_cnt    = r_len - r_cur - LW'(1);
                    n_src    = AW'(r_cur + LW'(1));
                    n_up     = 1'b0;
                    n_len    = r_len - LW'(1);
                    n_status = ST_APPLIED;
                end
            end
            OP_FORWARD: begin
                if (!r_end) begin
                    n_cur    = r_cur + LW'(1);
                    n_status = ST_APPLIED;
                end
            end
            OP_BACK: begin
                if (r_end) begin
                    if (len_nz) begin
                        n_end    = 1'b0;
                        n_cur    = r_len - LW'(1);
                        n_status = ST_APPLIED;
                    end
                end else if (r_cur != '0) begin
                    n_cur    = r_cur - LW'(1);
                    n_status = ST_APPLIED;
                end
            end
            OP_HOME: begin
                n_end    = 1'b0;
                n_cur    = '0;
                n_status = ST_APPLIED;
            end
            OP_END: begin
                n_end    = 1'b1;
                n_cur    = '0;
                n_status = ST_APPLIED;
            end
            OP_SET: begin
                set_op   = 1'b1;
                n_status = ST_APPLIED;
            end
            OP_READ: begin
                if (pos_ok) begin
                    n_rd_ok  = 1'b1;
                    n_status = ST_APPLIED;
                end
            end
            default: begin
                n_status = ST_NOEFFECT;
            end
        endcase

        // A cursor that is not below the length means end of text.
        if (set_op) begin
            n_end = !pos_ok;
            n_cur = pos_ok ? LW'(r_pos) : '0;
        end else if (n_end || (n_cur >= n_len)) begin
            n_end = 1'b1;
            n_cur = '0;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_ins_addr;
        wdata = r_ch;
        if (i_cmd.exec && app_we) begin
            we    = 1'b1;
            waddr = AW'(r_len);
        end else if (i_cmd.shift_wr) begin
            we    = 1'b1;
            waddr = r_up ? (r_src + AW'(1)) : (r_src - AW'(1));
            wdata = r_mem_q;
        end else if (i_cmd.ins_wr) begin
            we    = 1'b1;
        end
    end

    assign re    = (i_cmd.exec && (r_op == OP_READ) && pos_ok) || i_cmd.shift_rd;
    assign raddr = i_cmd.exec ? AW'(r_pos) : r_src;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_mem_q <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cur <= '0;
            r_end <= 1'b1;
            for (int k = 0; k < NUM_USED; k++) begin
                r_excl[k] <= 8'h00;
            end
        end else begin
            if (i_cfg_valid) begin
                for (int k = 0; k < NUM_USED; k++) begin
                    if (i_cfg_index == CFG_IDX_W'(k)) begin
                        r_excl[k] <= i_cfg_data;
                    end
                end
            end
            if (i_cmd.exec) begin
                r_len <= n_len;
                r_cur <= n_cur;
                r_end <= n_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_data.opcode;
            r_ch  <= i_in_data.char_code;
            r_pos <= i_in_data.position;
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_src      <= n_src;
            r_up       <= n_up;
            r_ins_mid  <= n_ins_mid;
            r_ins_addr <= n_ins_addr;
            r_rd_ok    <= n_rd_ok;
        end
        if (i_cmd.shift_wr) begin
            r_src <= r_up ? (r_src - AW'(1)) : (r_src + AW'(1));
        end
        if (i_cmd.load_out) begin
            r_out.status        <= r_status;
            r_out.text_length   <= 9'(r_len);
            r_out.cursor_index  <= 9'(r_cur);
            r_out.cursor_at_end <= r_end;
            r_out.read_char     <= r_rd_ok ? r_mem_q : 8'h00;
        end
    end

    // The move count is control state that the sequencer tests.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.exec) begin
            r_cnt <= n_cnt;
        end else if (i_cmd.shift_wr) begin
            r_cnt <= r_cnt - LW'(1);
        end
    end

    assign o_sts.cnt_nz   = (r_cnt != '0);
    assign o_sts.cnt_last = (r_cnt == LW'(1));
    assign o_sts.ins_mid  = r_ins_mid;
    assign o_out_data     = r_out;

endmodule

### rtl/core/line_edit_buffer_top.sv
// A request passes through execution and routing, then a read and a write for each stored
// character moved by a mid-text insert, backspace or delete, then an extra write for a
// mid-text insert, and waits in the done state until the result can be loaded.
// Only one request is worked on at a time and the next is accepted in the cycle after
// the result is loaded; a stalled result holds the input off. Reset is synchronous,
// active low: empty text, cursor at end, all exclude codes cleared to zero.
module line_edit_buffer_top #(
    parameter int MAX_LEN     = lebuf_pkg::MAX_LEN_DEF,
    parameter int NUM_EXCLUDE = lebuf_pkg::NUM_EXCLUDE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lebuf_pkg::t_in                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lebuf_pkg::t_out                 o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lebuf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);
    import lebuf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    lebuf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lebuf_dp #(
        .MAX_LEN     (MAX_LEN),
        .NUM_EXCLUDE (NUM_EXCLUDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lebuf_pkg::*;

    localparam int MAX_LEN       = MAX_LEN_DEF;
    localparam int NUM_EXCLUDE   = NUM_EXCLUDE_DEF;
    localparam int STALL_LIMIT   = 4000;
    localparam int PRESSURE_HOLD = 400;
    localparam int DRAIN_TAIL    = 2 * MAX_LEN + 8;
    localparam int NUM_ROWS      = 25;

    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_3 = 4'd3;

    typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} t_key_mix;

    typedef struct packed {
        t_in  req;
        logic typed;
        t_out want;
    } t_key_row;

    localparam t_out NO_WANT = '0;

    // Rows with typed set carry a result that is obvious from an empty or
    // nearly empty buffer; the rest are checked against the line model below.
    t_key_row directed_rows [NUM_ROWS] = '{
        '{'{OP_READ,      8'h00, 8'h00}, 1'b1, '{ST_NOEFFECT, 9'd0, 9'd0, 1'b1, 8'h00}},
        '{'{OP_BACKSPACE, 8'h00, 8'h00}, 1'b1, '{ST_NOEFFECT, 9'd0, 9'd0, 1'b1, 8'h00}},
        '{'{OP_DELETE,    8'h00, 8'h00}, 1'b1, '{ST_NOEFFECT, 9'd0, 9'd0, 1'b1, 8'h00}},
        '{'{OP_BACK,      8'h00, 8'h00}, 1'b1, '{ST_NOEFFECT, 9'd0, 9'd0, 1'b1, 8'h00}},
        '{'{OP_HOME,      8'h00, 8'h00}, 1'b1, '{ST_APPLIED,  9'd0, 9'd0, 1'b1, 8'h00}},
        '{'{OP_FORWARD,   8'h00, 8'h00}, 1'b1, '{ST_NOEFFECT, 9'd0, 9'd0, 1'b1, 8'h00}},
        '{'{OP_INSERT,    8'h00, 8'h00}, 1'b1, '{ST_EXCLUDED, 9'd0, 9'd0, 1'b1, 8'h00}},
        '{'{OP_INSERT,    8'hFF, 8'h00}, 1'b1, '{ST_APPLIED,  9'd1, 9'd0, 1'b1, 8'h00}},
        '{'{OP_INSERT,    8'h01, 8'h00}, 1'b1, '{ST_APPLIED,  9'd2, 9'd0, 1'b1, 8'h00}},
        '{'{OP_INSERT,    8'hAA, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_HOME,      8'h00, 8'h00}, 1'b1, '{ST_APPLIED,  9'd3, 9'd0, 1'b0, 8'h00}},
        '{'{OP_INSERT,    8'h55, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_BACKSPACE, 8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_BACKSPACE, 8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_FORWARD,   8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_DELETE,    8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_SET,       8'h00, 8'hFF}, 1'b0, NO_WANT},
        '{'{OP_BACK,      8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_DELETE,    8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_READ,      8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_READ,      8'h00, 8'hFF}, 1'b0, NO_WANT},
        '{'{OP_SET,       8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{OP_END,       8'h00, 8'h00}, 1'b0, NO_WANT},
        '{'{4'hF,         8'hFF, 8'hFF}, 1'b0, NO_WANT},
        '{'{OP_BACKSPACE, 8'h00, 8'h00}, 1'b0, NO_WANT}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    logic in_stall;
    logic out_valid;
    logic cfg_ready;
    t_out out_data;

    // Line model state.
    logic [7:0] text_mem [MAX_LEN];
    logic [8:0] text_len = '0;
    logic [8:0] cur_pos  = '0;
    logic       at_end   = 1'b1;
    logic [7:0] excl [NUM_EXCLUDE] = '{default: 8'h00};

    t_out expected_results [$];

    int fail_count      = 0;
    int keys_sent       = 0;
    int results_checked = 0;
    int peak_len        = 0;
    int idle_cycles     = 0;
    int status_hits [4] = '{default: 0};
    bit send_calm       = 1'b0;

    line_edit_buffer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void settle_cursor();
        if (at_end || cur_pos >= text_len) begin
            at_end  = 1'b1;
            cur_pos = '0;
        end
    endfunction

    function automatic t_out apply_key(t_in req);
        t_out       res;
        logic [1:0] st;
        logic [7:0] rd;
        logic       hit;
        int         i;
        st  = ST_NOEFFECT;
        rd  = 8'h00;
        hit = 1'b0;
        settle_cursor();
        case (req.opcode)
            OP_INSERT: begin
                for (i = 0; i < NUM_EXCLUDE; i++) begin
                    if (excl[i] == req.char_code) hit = 1'b1;
                end
                if (hit) begin
                    st = ST_EXCLUDED;
                end else if (int'(text_len) >= MAX_LEN) begin
                    st = ST_FULL;
                end else begin
                    if (at_end) begin
                        text_mem[text_len] = req.char_code;
                    end else begin
                        for (i = int'(text_len); i > int'(cur_pos); i--) begin
                            text_mem[i] = text_mem[i-1];
                        end
                        text_mem[cur_pos] = req.char_code;
                        cur_pos++;
                    end
                    text_len++;
                    st = ST_APPLIED;
                end
            end
            OP_BACKSPACE: begin
                if (text_len != 0) begin
                    if (at_end) begin
                        text_len--;
                        st = ST_APPLIED;
                    end else if (cur_pos != 0) begin
                        for (i = int'(cur_pos) - 1; i + 1 < int'(text_len); i++) begin
                            text_mem[i] = text_mem[i+1];
                        end
                        text_len--;
                        cur_pos--;
                        st = ST_APPLIED;
                    end
                end
            end
            OP_DELETE: begin
                if (text_len != 0 && !at_end) begin
                    for (i = int'(cur_pos); i + 1 < int'(text_len); i++) begin
                        text_mem[i] = text_mem[i+1];
                    end
                    text_len--;
                    st = ST_APPLIED;
                end
            end
            OP_FORWARD: begin
                if (!at_end) begin
                    cur_pos++;
                    st = ST_APPLIED;
                end
            end
            OP_BACK: begin
                if (at_end) begin
                    if (text_len != 0) begin
                        at_end  = 1'b0;
                        cur_pos = text_len - 9'd1;
                        st      = ST_APPLIED;
                    end
                end else if (cur_pos != 0) begin
                    cur_pos--;
                    st = ST_APPLIED;
                end
            end
            OP_HOME: begin
                at_end  = 1'b0;
                cur_pos = '0;
                st      = ST_APPLIED;
            end
            OP_END: begin
                at_end  = 1'b1;
                cur_pos = '0;
                st      = ST_APPLIED;
            end
            OP_SET: begin
                at_end  = 1'b0;
                cur_pos = {1'b0, req.position};
                st      = ST_APPLIED;
            end
            OP_READ: begin
                if ({1'b0, req.position} < text_len) begin
                    rd = text_mem[req.position];
                    st = ST_APPLIED;
                end
            end
            default: begin
            end
        endcase
        settle_cursor();
        res = '{st, text_len, cur_pos, at_end, rd};
        return res;
    endfunction

    function automatic t_in draw_key(t_key_mix mix);
        t_in req;
        int  roll;
        int  w_ins;
        int  w_cut;
        int  w_move;
        int  w_read;
        int  p;
        case (mix)
            MIX_GROW:   begin w_ins = 85; w_cut = 4;  w_move = 7;  w_read = 3;  end
            MIX_SHRINK: begin w_ins = 15; w_cut = 52; w_move = 18; w_read = 10; end
            default:    begin w_ins = 35; w_cut = 24; w_move = 24; w_read = 12; end
        endcase
        req.char_code = 8'($urandom_range(0, 255));
        // Reuse an exclude code now and then so the drop path keeps getting hit.
        if ($urandom_range(0, (mix == MIX_GROW) ? 15 : 7) == 0) begin
            req.char_code = excl[$urandom_range(0, NUM_EXCLUDE - 1)];
        end
        p = $urandom_range(0, int'(text_len));
        if (p > 255) p = 255;
        req.position = ($urandom_range(0, 9) < 6) ? 8'(p) : 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < w_ins) begin
            req.opcode = OP_INSERT;
        end else if (roll < w_ins + w_cut) begin
            req.opcode = $urandom_range(0, 1) ? OP_BACKSPACE : OP_DELETE;
        end else if (roll < w_ins + w_cut + w_move) begin
            case ($urandom_range(0, 4))
                0:       req.opcode = OP_FORWARD;
                1:       req.opcode = OP_BACK;
                2:       req.opcode = OP_HOME;
                3:       req.opcode = OP_END;
                default: req.opcode = OP_SET;
            endcase
        end else if (roll < w_ins + w_cut + w_move + w_read) begin
            req.opcode = OP_READ;
        end else begin
            req.opcode = 4'($urandom_range(9, 15));
        end
        return req;
    endfunction

    function automatic int pick_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_checked, name, got, want));
        end
    endtask

    task automatic check_result(t_out got);
        t_out want;
        results_checked++;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding: %h",
                                      results_checked, got));
        end else begin
            want = expected_results.pop_front();
            compare_field("status", int'(got.status), int'(want.status));
            compare_field("text_length", int'(got.text_length), int'(want.text_length));
            compare_field("cursor_index", int'(got.cursor_index), int'(want.cursor_index));
            compare_field("cursor_at_end", int'(got.cursor_at_end), int'(want.cursor_at_end));
            compare_field("read_char", int'(got.read_char), int'(want.read_char));
        end
    endtask

    task automatic send_key(t_in req, logic typed, t_out want);
        int   gap;
        t_out predicted;
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        gap = pick_gap(send_calm);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        predicted = apply_key(req);
        expected_results = {expected_results, (typed ? want : predicted)};
        keys_sent++;
        status_hits[predicted.status]++;
        if (int'(text_len) > peak_len) peak_len = int'(text_len);
    endtask

    task automatic run_keys(t_key_mix mix, int count);
        repeat (count) send_key(draw_key(mix), 1'b0, NO_WANT);
    endtask

    // The last request was just accepted, so the block stalls its input while it works
    // on it; dropping valid at the next falling edge keeps it from repeating.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_exclude(logic [CFG_IDX_W-1:0] idx, logic [7:0] code);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= code;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_EXCLUDE_0: excl[0] = code;
            REG_EXCLUDE_1: excl[1] = code;
            REG_EXCLUDE_2: excl[2] = code;
            REG_EXCLUDE_3: excl[3] = code;
            default: begin
            end
        endcase
    endtask

    task automatic load_excludes(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                 logic [7:0] c3);
        write_exclude(REG_EXCLUDE_0, c0);
        write_exclude(REG_EXCLUDE_1, c1);
        write_exclude(REG_EXCLUDE_2, c2);
        write_exclude(REG_EXCLUDE_3, c3);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random hold-offs, with a long one now and then so the
    // block backs up and has to stall the key side.
    initial begin
        int   gap;
        bit   calm;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            if (results_checked % 250 == 60) begin
                gap = PRESSURE_HOLD;
            end else begin
                gap = pick_gap(calm);
            end
            repeat (gap) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            check_result(out_data);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no request moved for %0d cycles", STALL_LIMIT);
            $display("line_edit_buffer_top verification failed");
            $finish;
        end
    end

    initial begin
        int r;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Exclude registers still hold their reset value here, so code zero drops.
        for (r = 0; r < NUM_ROWS; r++) begin
            send_key(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want);
        end

        wait_drained();
        load_excludes(8'hFF, 8'h00, 8'h7F, 8'h80);
        run_keys(MIX_BALANCED, 80);

        // Fill the buffer to the brim, then keep typing into it.
        wait_drained();
        load_excludes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        while (int'(text_len) < MAX_LEN) send_key(draw_key(MIX_GROW), 1'b0, NO_WANT);
        run_keys(MIX_GROW, 15);

        wait_drained();
        load_excludes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_keys(MIX_SHRINK, 70);

        wait_drained();
        load_excludes(8'h00, 8'($urandom), 8'($urandom), 8'hFF);
        run_keys(MIX_BALANCED, 60);

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Summary: %0d key events, %0d results checked, peak text length %0d.",
                 keys_sent, results_checked, peak_len);
        $display("Summary: applied %0d, no effect %0d, excluded %0d, buffer full %0d.",
                 status_hits[ST_APPLIED], status_hits[ST_NOEFFECT],
                 status_hits[ST_EXCLUDED], status_hits[ST_FULL]);
        if (fail_count == 0) begin
            $display("line_edit_buffer_top verification clean");
        end else begin
            $display("line_edit_buffer_top verification failed");
        end
        $finish;
    end

endmodule
